// ----- rtl/dmm_pkg.sv -----
// Shared types and constants for the dense matrix multiply core.
package dmm_pkg;

    localparam int MAX_N_DEF      = 64;
    localparam int ELEM_WIDTH_DEF = 16;

    localparam int FUNC_W    = 2;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 16;
    localparam int SIZE_W    = 7;
    localparam int PRODUCT_W = 38;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_A = 2'd0,
        FUNC_WRITE_B = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic data_vld;
    } mac_ctl_t;

endpackage

// ----- rtl/dense_matrix_multiply_core.sv -----
// Top level of the dense matrix multiply core: element stores and read sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | in        | in_valid / in_stall  | func, row, col, value
//  out     | out       | out_valid / out_stall| product, out_of_range
//  cfg     | in        | cfg_valid / cfg_ready| cfg_size
//
// A product read walks k from 0 to n-1, one A and one B element per
// cycle from the two stores; a read outside the matrix skips the walk.
// The single read port of each store sets that rate. Reset clears control
// only; the stores hold nothing defined until written. A finished result
// waits in the output register under out_stall while the next request
// is taken.
module dense_matrix_multiply_core #(
    parameter int MAX_N      = dmm_pkg::MAX_N_DEF,
    parameter int ELEM_WIDTH = dmm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // requests
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dmm_pkg::FUNC_W-1:0]        func,
    input  logic [dmm_pkg::INDEX_W-1:0]       row,
    input  logic [dmm_pkg::INDEX_W-1:0]       col,
    input  logic signed [dmm_pkg::VALUE_W-1:0] value,
    // results
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [dmm_pkg::PRODUCT_W-1:0] product,
    output logic                              out_of_range,
    // size register
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dmm_pkg::SIZE_W-1:0]        cfg_size
);

    localparam int IDX_W  = $clog2(MAX_N);
    localparam int NW     = $clog2(MAX_N + 1);
    localparam int CW     = (NW > dmm_pkg::SIZE_W) ? NW : dmm_pkg::SIZE_W;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    // configuration
    logic [dmm_pkg::SIZE_W-1:0] size_reg;
    logic [CW-1:0]              size_cw;
    logic [CW-1:0]              n_cw;
    logic                       in_range;

    // sequencer
    dmm_pkg::state_t            state_reg;
    dmm_pkg::state_t            state_next;
    logic [IDX_W-1:0]           row_reg;
    logic [IDX_W-1:0]           col_reg;
    logic [IDX_W-1:0]           k_reg;
    logic [IDX_W-1:0]           k_next;
    logic [NW-1:0]              n_reg;
    logic [NW-1:0]              k_ext;
    logic                       last_k;
    logic                       in_range_reg;
    logic                       in_acc;
    logic                       is_read;
    logic                       rd_en;
    logic                       load_out;
    logic                       slot_free;

    // stores
    logic [ELEM_WIDTH-1:0]      a_mem [DEPTH];
    logic [ELEM_WIDTH-1:0]      b_mem [DEPTH];
    logic [ELEM_WIDTH-1:0]      a_q_reg;
    logic [ELEM_WIDTH-1:0]      b_q_reg;
    logic                       q_vld_reg;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          a_rd_addr;
    logic [ADDR_W-1:0]          b_rd_addr;
    logic [ELEM_WIDTH+dmm_pkg::VALUE_W-1:0] value_ext;
    logic [ELEM_WIDTH-1:0]      wr_elem;
    logic                       wr_a;
    logic                       wr_b;

    // accumulator
    dmm_pkg::mac_ctl_t          mac_ctl;
    logic [dmm_pkg::PRODUCT_W-1:0] acc;
    logic                       mac_busy;

    // output register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [dmm_pkg::PRODUCT_W-1:0] product_reg;
    logic                       oor_reg;

    // ---------------------------------------------------------------
    // Size register; n saturates to MAX_N
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= dmm_pkg::SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_size;
        end
    end

    assign size_cw  = CW'(size_reg);
    assign n_cw     = (size_cw > CW'(MAX_N)) ? CW'(MAX_N) : size_cw;
    assign in_range = (CW'(row) < n_cw) && (CW'(col) < n_cw);

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    assign in_acc  = in_valid && !in_stall;
    assign is_read = (func == dmm_pkg::FUNC_READ);

    // element is the low ELEM_WIDTH bits of value, zero above its 16 bits
    assign value_ext = {{ELEM_WIDTH{1'b0}}, value};
    assign wr_elem   = value_ext[ELEM_WIDTH-1:0];
    assign wr_addr   = {IDX_W'(row), IDX_W'(col)};
    assign wr_a      = in_acc && in_range && (func == dmm_pkg::FUNC_WRITE_A);
    assign wr_b      = in_acc && in_range && (func == dmm_pkg::FUNC_WRITE_B);

    // ---------------------------------------------------------------
    // Stores: A walks along a row, B down a column
    // ---------------------------------------------------------------
    assign a_rd_addr = {row_reg, k_reg};
    assign b_rd_addr = {k_reg, col_reg};

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_mem[wr_addr] <= wr_elem;
        end
        if (rd_en)
        begin
            a_q_reg <= a_mem[a_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            b_mem[wr_addr] <= wr_elem;
        end
        if (rd_en)
        begin
            b_q_reg <= b_mem[b_rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign k_ext  = NW'(k_reg);
    assign last_k = (k_ext == (n_reg - NW'(1)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dmm_pkg::ST_IDLE:
            begin
                if (in_acc && is_read)
                begin
                    state_next = in_range ? dmm_pkg::ST_RUN : dmm_pkg::ST_FINISH;
                end
            end
            dmm_pkg::ST_RUN:
            begin
                if (last_k)
                begin
                    state_next = dmm_pkg::ST_DRAIN;
                end
            end
            dmm_pkg::ST_DRAIN:
            begin
                if (!q_vld_reg && !mac_busy)
                begin
                    state_next = dmm_pkg::ST_FINISH;
                end
            end
            dmm_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = dmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall         = 1'b1;
        rd_en            = 1'b0;
        load_out         = 1'b0;
        mac_ctl.clear    = 1'b0;
        mac_ctl.data_vld = q_vld_reg;
        unique case (state_reg)
            dmm_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                mac_ctl.clear = in_acc && is_read;
            end
            dmm_pkg::ST_RUN:
            begin
                rd_en = 1'b1;
            end
            dmm_pkg::ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            dmm_pkg::ST_FINISH:
            begin
                load_out = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        k_next = k_reg;
        if (in_acc)
        begin
            k_next = '0;
        end
        else if (rd_en)
        begin
            k_next = k_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmm_pkg::ST_IDLE;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            q_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (in_acc)
        begin
            row_reg      <= IDX_W'(row);
            col_reg      <= IDX_W'(col);
            n_reg        <= NW'(n_cw);
            in_range_reg <= in_range;
        end
    end

    // ---------------------------------------------------------------
    // Multiply-accumulate
    // ---------------------------------------------------------------
    dmm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a_q   (a_q_reg),
        .b_q   (b_q_reg),
        .acc   (acc),
        .busy  (mac_busy)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            // out-of-range read: accumulator was cleared and never ran
            product_reg <= acc;
            oor_reg     <= !in_range_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign product      = product_reg;
    assign out_of_range = oor_reg;

endmodule

// ----- rtl/dmm_mac.sv -----
// Multiply-accumulate datapath: registered product, then wrapping accumulator.
module dmm_mac #(
    parameter int ELEM_WIDTH = dmm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmm_pkg::mac_ctl_t                    ctl,
    input  logic signed [ELEM_WIDTH-1:0]         a_q,
    input  logic signed [ELEM_WIDTH-1:0]         b_q,
    output logic [dmm_pkg::PRODUCT_W-1:0]        acc,
    output logic                                 busy
);

    localparam int PW = 2 * ELEM_WIDTH;

    logic signed [PW-1:0]                   prod_reg;
    logic                                   prod_vld_reg;
    logic [dmm_pkg::PRODUCT_W-1:0]          acc_reg;
    logic [dmm_pkg::PRODUCT_W-1:0]          acc_next;
    logic [PW+dmm_pkg::PRODUCT_W-1:0]       prod_ext;

    // sign-extend, then keep the low bits: the sum wraps
    assign prod_ext = {{dmm_pkg::PRODUCT_W{prod_reg[PW-1]}}, prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + prod_ext[dmm_pkg::PRODUCT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.data_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_q * b_q;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule

// ----- test/tb_dense_matrix_multiply_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the dense matrix multiply core: A/B element writes and product reads.
module tb_dense_matrix_multiply_core;

    localparam int MAX_N           = dmm_pkg::MAX_N_DEF;
    localparam int RESET_CYCLES    = 12;
    localparam int ITEM_TARGET     = 1650;
    localparam int PHASE_ITEMS     = 110;
    localparam int DRAIN_CYCLES    = 80;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic signed [dmm_pkg::VALUE_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [dmm_pkg::VALUE_W-1:0] ELEM_MAX = 16'sh7fff;

    // Sizes walked by the random phases: mostly small, a few at or above MAX_N.
    localparam int PHASE_SIZES [14] = '{1, 3, 8, 64, 5, 2, 100, 4, 16, 7, 1, 6, 12, 3};

    typedef struct packed {
        logic signed [dmm_pkg::PRODUCT_W-1:0] product;
        logic                                 out_of_range;
    } product_result_t;

    // Keeps its own copy of both element stores and of the size register, and
    // the products still owed by the core, oldest first.
    class product_tracker;
        bit signed [dmm_pkg::VALUE_W-1:0] a_elems [MAX_N*MAX_N];
        bit signed [dmm_pkg::VALUE_W-1:0] b_elems [MAX_N*MAX_N];
        int unsigned                      size_reg;
        product_result_t                  pending_products [$];
        int                               mismatches;

        function new();
            size_reg   = dmm_pkg::SIZE_RESET;
            mismatches = 0;
        endfunction

        function void load_size(logic [dmm_pkg::SIZE_W-1:0] v);
            size_reg = v;
        endfunction

        function int unsigned pending();
            return pending_products.size();
        endfunction

        function void note_request(dmm_pkg::func_t f, logic [dmm_pkg::INDEX_W-1:0] r,
                                   logic [dmm_pkg::INDEX_W-1:0] c,
                                   logic signed [dmm_pkg::VALUE_W-1:0] v);
            int unsigned     n;
            bit              in_bounds;
            longint          acc;
            product_result_t res;
            n         = (size_reg > MAX_N) ? MAX_N : size_reg;
            in_bounds = (r < n) && (c < n);
            case (f)
                dmm_pkg::FUNC_WRITE_A:
                    if (in_bounds)
                        a_elems[r*MAX_N+c] = v;
                dmm_pkg::FUNC_WRITE_B:
                    if (in_bounds)
                        b_elems[r*MAX_N+c] = v;
                dmm_pkg::FUNC_READ:
                begin
                    // exact sum; out of range answers zero with the flag set
                    acc = 0;
                    if (in_bounds)
                        for (int k = 0; k < n; k++)
                            acc += longint'(a_elems[r*MAX_N+k]) *
                                   longint'(b_elems[k*MAX_N+c]);
                    res.product      = acc[dmm_pkg::PRODUCT_W-1:0];
                    res.out_of_range = !in_bounds;
                    pending_products.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_product(logic signed [dmm_pkg::PRODUCT_W-1:0] p, logic oor);
            product_result_t want;
            if (pending_products.size() == 0)
            begin
                $display("%0t: result with none expected: product %0d out_of_range %0b",
                         $time, p, oor);
                mismatches++;
                return;
            end
            want = pending_products.pop_front();
            if (p !== want.product)
            begin
                $display("%0t: product mismatch: expected %0d actual %0d",
                         $time, $signed(want.product), p);
                mismatches++;
            end
            if (oor !== want.out_of_range)
            begin
                $display("%0t: out_of_range mismatch: expected %0b actual %0b",
                         $time, want.out_of_range, oor);
                mismatches++;
            end
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic [dmm_pkg::FUNC_W-1:0]           func;
    logic [dmm_pkg::INDEX_W-1:0]          row;
    logic [dmm_pkg::INDEX_W-1:0]          col;
    logic signed [dmm_pkg::VALUE_W-1:0]   value;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [dmm_pkg::PRODUCT_W-1:0] product;
    logic                                 out_of_range;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [dmm_pkg::SIZE_W-1:0]           cfg_size;

    product_tracker tracker;

    // Stimulus side bookkeeping: which store entries hold a defined value, so
    // that a read in range never touches an entry that was never written.
    bit          a_written [MAX_N*MAX_N];
    bit          b_written [MAX_N*MAX_N];
    int unsigned gen_n;
    int unsigned item_count;
    bit          burst_mode;
    bit          hold_off_req;
    bit          hold_off_done;
    int unsigned quiet_cycles;

    dense_matrix_multiply_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .row          (row),
        .col          (col),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .product      (product),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_size     (cfg_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int unsigned idle_cycles(bit no_gaps);
        int unsigned pick;
        if (no_gaps)
            return 0;
        pick = $urandom_range(99, 0);
        if (pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(3, 1);
        if (pick < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic signed [dmm_pkg::VALUE_W-1:0] random_elem();
        return dmm_pkg::VALUE_W'($urandom);
    endfunction

    // Read index: full spread at small sizes, only the edges at large ones to
    // keep the operand fill short.
    function automatic logic [dmm_pkg::INDEX_W-1:0] read_spot();
        if (gen_n > 8)
            return dmm_pkg::INDEX_W'($urandom_range(1, 0) ? gen_n - 1 : 0);
        return dmm_pkg::INDEX_W'($urandom_range(gen_n - 1, 0));
    endfunction

    task automatic send_request(dmm_pkg::func_t f, logic [dmm_pkg::INDEX_W-1:0] r,
                                logic [dmm_pkg::INDEX_W-1:0] c,
                                logic signed [dmm_pkg::VALUE_W-1:0] v);
        int unsigned gap;
        gap = idle_cycles(burst_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        row      <= r;
        col      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (r < gen_n && c < gen_n)
        begin
            if (f == dmm_pkg::FUNC_WRITE_A)
                a_written[r*MAX_N+c] = 1'b1;
            if (f == dmm_pkg::FUNC_WRITE_B)
                b_written[r*MAX_N+c] = 1'b1;
        end
        if (f != dmm_pkg::FUNC_NONE)
            item_count++;
    endtask

    // Write whatever of A row r and B column c is still undefined.
    task automatic fill_operands(logic [dmm_pkg::INDEX_W-1:0] r,
                                 logic [dmm_pkg::INDEX_W-1:0] c);
        for (int k = 0; k < gen_n; k++)
        begin
            if (!a_written[r*MAX_N+k])
                send_request(dmm_pkg::FUNC_WRITE_A, r, dmm_pkg::INDEX_W'(k), random_elem());
            if (!b_written[k*MAX_N+c])
                send_request(dmm_pkg::FUNC_WRITE_B, dmm_pkg::INDEX_W'(k), c, random_elem());
        end
    endtask

    // Size changes only with the core idle: all products back, then a pause
    // long enough for the slowest read to have finished.
    task automatic set_matrix_size(logic [dmm_pkg::SIZE_W-1:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_size  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.load_size(v);
        gen_n = (v > MAX_N) ? MAX_N : v;
    endtask

    // Mix: writes in and out of range, reads in range preceded by their
    // operand fill, reads out of range, and the unused code.
    task automatic run_random_phase(int unsigned count);
        int unsigned                 pick;
        bit                          outside_n;
        logic [dmm_pkg::INDEX_W-1:0] r;
        logic [dmm_pkg::INDEX_W-1:0] c;
        repeat (count)
        begin
            pick      = $urandom_range(99, 0);
            outside_n = ((pick >= 35 && pick < 45) || (pick >= 85 && pick < 95))
                        && gen_n < MAX_N;
            if (gen_n == 0)
                outside_n = 1'b1;
            if (outside_n)
            begin
                if ($urandom_range(1, 0))
                begin
                    r = dmm_pkg::INDEX_W'($urandom_range(MAX_N - 1, gen_n));
                    c = dmm_pkg::INDEX_W'($urandom);
                end
                else
                begin
                    r = dmm_pkg::INDEX_W'($urandom);
                    c = dmm_pkg::INDEX_W'($urandom_range(MAX_N - 1, gen_n));
                end
            end
            else if (pick < 45)
            begin
                r = dmm_pkg::INDEX_W'($urandom_range(gen_n - 1, 0));
                c = dmm_pkg::INDEX_W'($urandom_range(gen_n - 1, 0));
            end
            else
            begin
                r = read_spot();
                c = read_spot();
            end

            if (pick >= 95)
                send_request(dmm_pkg::FUNC_NONE, dmm_pkg::INDEX_W'($urandom),
                             dmm_pkg::INDEX_W'($urandom), random_elem());
            else if (pick < 45)
                send_request($urandom_range(1, 0) ? dmm_pkg::FUNC_WRITE_B
                                                  : dmm_pkg::FUNC_WRITE_A,
                             r, c, random_elem());
            else
            begin
                if (!outside_n)
                    fill_operands(r, c);
                send_request(dmm_pkg::FUNC_READ, r, c, random_elem());
            end
        end
    endtask

    // Result side: random stall stretches, quiet stretches, and one long
    // hold-off that lets the core back up into its request channel.
    initial
    begin
        int unsigned busy;
        int unsigned free_run;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                busy = idle_cycles(1'b0);
                if (busy > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (busy) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            free_run = ($urandom_range(9, 0) == 0) ? $urandom_range(150, 40)
                                                    : $urandom_range(6, 1);
            repeat (free_run) @(posedge clk);
        end
    end

    // Monitor and watchdog. Requests are noted before results are checked so
    // that a request and an older result in the same cycle stay in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_request(dmm_pkg::func_t'(func), row, col, value);
            if (out_valid && !out_stall)
                tracker.check_product(product, out_of_range);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL dense_matrix_multiply_core");
                $finish;
            end
        end
    end

    initial
    begin
        tracker       = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = dmm_pkg::FUNC_WRITE_A;
        row           = '0;
        col           = '0;
        value         = '0;
        cfg_valid     = 1'b0;
        cfg_size      = '0;
        gen_n         = MAX_N;
        item_count    = 0;
        burst_mode    = 1'b0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        quiet_cycles  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // 2x2: element extremes, every code, reads and writes outside n
        set_matrix_size(7'd2);
        send_request(dmm_pkg::FUNC_WRITE_A, 6'd0, 6'd0, ELEM_MIN);
        send_request(dmm_pkg::FUNC_WRITE_A, 6'd0, 6'd1, ELEM_MAX);
        send_request(dmm_pkg::FUNC_WRITE_B, 6'd0, 6'd0, ELEM_MIN);
        send_request(dmm_pkg::FUNC_WRITE_B, 6'd1, 6'd0, ELEM_MAX);
        send_request(dmm_pkg::FUNC_READ, 6'd0, 6'd0, '0);
        send_request(dmm_pkg::FUNC_WRITE_A, 6'd1, 6'd0, -16'sd1);
        send_request(dmm_pkg::FUNC_WRITE_A, 6'd1, 6'd1, ELEM_MIN);
        send_request(dmm_pkg::FUNC_WRITE_B, 6'd0, 6'd1, ELEM_MAX);
        send_request(dmm_pkg::FUNC_WRITE_B, 6'd1, 6'd1, ELEM_MIN);
        send_request(dmm_pkg::FUNC_READ, 6'd1, 6'd1, '0);
        send_request(dmm_pkg::FUNC_READ, 6'd0, 6'd1, ELEM_MAX);
        send_request(dmm_pkg::FUNC_READ, 6'd63, 6'd0, '0);
        send_request(dmm_pkg::FUNC_READ, 6'd0, 6'd2, '0);
        // ignored: outside n, and the unused code; then a read in range
        send_request(dmm_pkg::FUNC_WRITE_A, 6'd63, 6'd63, 16'sh5555);
        send_request(dmm_pkg::FUNC_WRITE_B, 6'd2, 6'd0, 16'sh2aaa);
        send_request(dmm_pkg::FUNC_NONE, 6'd63, 6'd63, -16'sd1);
        send_request(dmm_pkg::FUNC_READ, 6'd1, 6'd0, '0);

        // size zero: nothing is in range
        set_matrix_size(7'd0);
        send_request(dmm_pkg::FUNC_READ, 6'd0, 6'd0, '0);
        send_request(dmm_pkg::FUNC_WRITE_A, 6'd0, 6'd0, 16'sd1);
        send_request(dmm_pkg::FUNC_READ, 6'd0, 6'd0, '0);

        // size above MAX_N saturates; full-length dot products at the element
        // extremes give the largest and the most negative product
        set_matrix_size(7'd127);
        burst_mode = 1'b1;
        for (int k = 0; k < MAX_N; k++)
        begin
            send_request(dmm_pkg::FUNC_WRITE_A, 6'd0, dmm_pkg::INDEX_W'(k), ELEM_MIN);
            send_request(dmm_pkg::FUNC_WRITE_B, dmm_pkg::INDEX_W'(k), 6'd0, ELEM_MIN);
            send_request(dmm_pkg::FUNC_WRITE_A, 6'd63, dmm_pkg::INDEX_W'(k), ELEM_MAX);
            send_request(dmm_pkg::FUNC_WRITE_B, dmm_pkg::INDEX_W'(k), 6'd63, ELEM_MIN);
        end
        burst_mode = 1'b0;
        send_request(dmm_pkg::FUNC_READ, 6'd0, 6'd0, '0);
        send_request(dmm_pkg::FUNC_READ, 6'd63, 6'd63, '0);
        send_request(dmm_pkg::FUNC_READ, 6'd0, 6'd63, '0);
        send_request(dmm_pkg::FUNC_READ, 6'd63, 6'd0, '0);
        run_random_phase(60);

        for (int p = 0; item_count < ITEM_TARGET; p++)
        begin
            set_matrix_size(dmm_pkg::SIZE_W'(PHASE_SIZES[p % $size(PHASE_SIZES)]));
            burst_mode = ($urandom_range(3, 0) == 0);
            if (p == 1)
                hold_off_req = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("PASS dense_matrix_multiply_core");
        else
            $display("FAIL dense_matrix_multiply_core");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dmm_pkg.sv
rtl/dmm_mac.sv
rtl/dense_matrix_multiply_core.sv
test/tb_dense_matrix_multiply_core.sv
